// File: rtl/cip_pkg.sv
// Shared types and codes for the compression identification packet parser.
// Depends on nothing; every other file in rtl/ uses it by scoped names.
`default_nettype none

package cip_pkg;

  // Most results one packet byte can produce
  localparam int unsigned RES_MAX = 3;

  // Field codes of a result
  localparam logic [3:0] FLD_TYPE        = 4'd0;
  localparam logic [3:0] FLD_APID        = 4'd1;
  localparam logic [3:0] FLD_SEQFLAG     = 4'd2;
  localparam logic [3:0] FLD_SEQCOUNT    = 4'd3;
  localparam logic [3:0] FLD_DATALEN     = 4'd4;
  localparam logic [3:0] FLD_GROUPS      = 4'd5;
  localparam logic [3:0] FLD_TECHNIQUE   = 4'd6;
  localparam logic [3:0] FLD_REFINTERVAL = 4'd7;
  localparam logic [3:0] FLD_PREPROC     = 4'd8;
  localparam logic [3:0] FLD_PREDICTOR   = 4'd9;
  localparam logic [3:0] FLD_MAPPER      = 4'd10;
  localparam logic [3:0] FLD_BLOCK       = 4'd11;
  localparam logic [3:0] FLD_SENSE       = 4'd12;
  localparam logic [3:0] FLD_RESOLUTION  = 4'd13;
  localparam logic [3:0] FLD_OPTION      = 4'd14;
  localparam logic [3:0] FLD_CDS         = 4'd15;

  // Error codes, in order of the checks
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_VERSION     = 4'd1;
  localparam logic [3:0] ERR_SEC_HDR     = 4'd2;
  localparam logic [3:0] ERR_TECHNIQUE   = 4'd3;
  localparam logic [3:0] ERR_PREPROC_HDR = 4'd4;
  localparam logic [3:0] ERR_ENTROPY_HDR = 4'd5;
  localparam logic [3:0] ERR_PREDICTOR   = 4'd6;
  localparam logic [3:0] ERR_MAPPER      = 4'd7;
  localparam logic [3:0] ERR_BLOCK_RSVD  = 4'd8;
  localparam logic [3:0] ERR_BLOCK_APP   = 4'd9;
  localparam logic [3:0] ERR_SENSE       = 4'd10;
  localparam logic [3:0] ERR_OPTION_ZERO = 4'd11;
  localparam logic [3:0] ERR_OPTION_RES  = 4'd12;
  localparam logic [3:0] ERR_DATA_LEN    = 4'd13;

  // Byte positions within the packet
  localparam logic [3:0] POS_HDR0  = 4'd0;
  localparam logic [3:0] POS_HDR1  = 4'd1;
  localparam logic [3:0] POS_HDR2  = 4'd2;
  localparam logic [3:0] POS_HDR3  = 4'd3;
  localparam logic [3:0] POS_HDR4  = 4'd4;
  localparam logic [3:0] POS_HDR5  = 4'd5;
  localparam logic [3:0] POS_SRC0  = 4'd6;
  localparam logic [3:0] POS_SRC1  = 4'd7;
  localparam logic [3:0] POS_SRC2  = 4'd8;
  localparam logic [3:0] POS_SRC3  = 4'd9;
  localparam logic [3:0] POS_PRE0  = 4'd10;
  localparam logic [3:0] POS_PRE1  = 4'd11;
  localparam logic [3:0] POS_ENT0  = 4'd12;
  localparam logic [3:0] POS_ENT1  = 4'd13;
  localparam logic [3:0] POS_LAST  = 4'd15;

  // One result item
  typedef struct packed {
    logic [3:0]  field_code;
    logic [15:0] field_value;
    logic [3:0]  error_code;
    logic        last_result;
  } result_t;

  typedef result_t [RES_MAX-1:0] res_vec_t;

  // Parse state kept between bytes
  typedef struct packed {
    logic [3:0]  pos;
    logic        idle;
    logic [7:0]  held;
    logic        lossless;
    logic        preproc;
    logic [5:0]  resolution;
    logic [15:0] data_len;
  } parse_state_t;

endpackage

`default_nettype wire

// File: rtl/cip_decode.sv
// Parse state register and per-byte field decode with validity checks.
// Depends on cip_pkg for result and state types and all codes.
`default_nettype none

module cip_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        data_byte,
  input  wire logic              first_byte,
  output logic [1:0]             res_cnt,
  output cip_pkg::res_vec_t      res
);

  cip_pkg::parse_state_t st_r;
  cip_pkg::parse_state_t st_nxt;

  cip_pkg::parse_state_t cur;
  logic                  fail_en;
  logic [3:0]            fail_err;
  logic                  ent_first;
  logic                  ent_second;
  logic [1:0]            opt;
  logic                  opt_mismatch;
  logic [16:0]            len_plus1;
  logic [16:0]            used_bytes;
  logic [2:0]            pred_code;
  logic [1:0]            map_code;
  logic [15:0]           pred_val;
  logic [15:0]           map_val;
  logic                  pred_ok;
  logic                  map_ok;
  logic [5:0]            new_res;

  function automatic cip_pkg::result_t mk(input logic [3:0] code, input logic [15:0] value,
                                          input logic last);
    cip_pkg::result_t r;
    r.field_code  = code;
    r.field_value = value;
    r.error_code  = cip_pkg::ERR_NONE;
    r.last_result = last;
    return r;
  endfunction

  // Option code against the sample resolution
  always_comb begin
    opt = data_byte[5:4];
    unique case (opt)
      2'd1:    opt_mismatch = (cur.resolution > 6'd8);
      2'd2:    opt_mismatch = (cur.resolution <= 6'd8) || (cur.resolution > 6'd16);
      2'd3:    opt_mismatch = (cur.resolution <= 6'd16) || (cur.resolution > 6'd32);
      default: opt_mismatch = 1'b0;
    endcase
  end

  // Predictor and mapper code translation
  always_comb begin
    pred_code = data_byte[4:2];
    map_code  = data_byte[1:0];
    pred_ok   = 1'b1;
    pred_val  = 16'd0;
    unique case (pred_code)
      3'd0:    pred_val = 16'd0;
      3'd1:    pred_val = 16'd1;
      3'd7:    pred_val = 16'd2;
      default: pred_ok  = 1'b0;
    endcase
    map_ok  = 1'b1;
    map_val = 16'd0;
    unique case (map_code)
      2'd0:    map_val = 16'd0;
      2'd3:    map_val = 16'd1;
      default: map_ok  = 1'b0;
    endcase
  end

  // Decode one byte against the current state
  always_comb begin
    cur = st_r;
    if (first_byte) begin
      cur      = '0;
      cur.idle = 1'b0;
    end
    st_nxt     = cur;
    res        = '0;
    res_cnt    = 2'd0;
    fail_en    = 1'b0;
    fail_err   = cip_pkg::ERR_NONE;
    ent_first  = (cur.pos == cip_pkg::POS_ENT0) ||
                 ((cur.pos == cip_pkg::POS_PRE0) && !cur.lossless);
    ent_second = (cur.pos == cip_pkg::POS_ENT1) ||
                 ((cur.pos == cip_pkg::POS_PRE1) && !cur.lossless);
    len_plus1  = {1'b0, cur.data_len} + 17'd1;
    used_bytes = cur.lossless ? 17'd8 : 17'd6;
    new_res    = {1'b0, data_byte[4:0]} + 6'd1;

    if (!cur.idle) begin
      if (cur.pos != cip_pkg::POS_LAST) begin
        st_nxt.pos = cur.pos + 4'd1;
      end
      if (ent_first) begin
        // Entropy coder field, first byte
        if (data_byte[7:6] != 2'b01) begin
          fail_en  = 1'b1;
          fail_err = cip_pkg::ERR_ENTROPY_HDR;
        end else if (opt == 2'd0) begin
          fail_en  = 1'b1;
          fail_err = cip_pkg::ERR_OPTION_ZERO;
        end else if (cur.lossless && opt_mismatch) begin
          fail_en  = 1'b1;
          fail_err = cip_pkg::ERR_OPTION_RES;
        end else begin
          st_nxt.held = data_byte;
          res[0]      = mk(cip_pkg::FLD_OPTION, {14'd0, opt - 2'd1}, 1'b0);
          res_cnt     = 2'd1;
        end
      end else if (ent_second) begin
        // Entropy coder field, second byte: length check and final result
        if (len_plus1 < used_bytes) begin
          fail_en  = 1'b1;
          fail_err = cip_pkg::ERR_DATA_LEN;
        end else begin
          res[0]      = mk(cip_pkg::FLD_CDS,
                           {4'd0, cur.held[3:0], data_byte} + 16'd1, 1'b1);
          res_cnt     = 2'd1;
          st_nxt.idle = 1'b1;
        end
      end else begin
        unique case (cur.pos)
          cip_pkg::POS_HDR0: begin
            if (data_byte[7:5] != 3'd0) begin
              fail_en  = 1'b1;
              fail_err = cip_pkg::ERR_VERSION;
            end else if (data_byte[3]) begin
              fail_en  = 1'b1;
              fail_err = cip_pkg::ERR_SEC_HDR;
            end else begin
              st_nxt.held = data_byte;
              res[0]      = mk(cip_pkg::FLD_TYPE, {15'd0, data_byte[4]}, 1'b0);
              res_cnt     = 2'd1;
            end
          end
          cip_pkg::POS_HDR1: begin
            res[0]  = mk(cip_pkg::FLD_APID, {5'd0, cur.held[2:0], data_byte}, 1'b0);
            res_cnt = 2'd1;
          end
          cip_pkg::POS_HDR2: begin
            st_nxt.held = data_byte;
            res[0]      = mk(cip_pkg::FLD_SEQFLAG, {14'd0, data_byte[7:6]}, 1'b0);
            res_cnt     = 2'd1;
          end
          cip_pkg::POS_HDR3: begin
            res[0]  = mk(cip_pkg::FLD_SEQCOUNT, {2'd0, cur.held[5:0], data_byte}, 1'b0);
            res_cnt = 2'd1;
          end
          cip_pkg::POS_HDR4, cip_pkg::POS_SRC0: begin
            st_nxt.held = data_byte;
          end
          cip_pkg::POS_HDR5: begin
            st_nxt.data_len = {cur.held, data_byte};
            res[0]          = mk(cip_pkg::FLD_DATALEN, {cur.held, data_byte}, 1'b0);
            res_cnt         = 2'd1;
          end
          cip_pkg::POS_SRC1: begin
            res[0]  = mk(cip_pkg::FLD_GROUPS,
                         {4'd0, cur.held[3:0], data_byte} + 16'd1, 1'b0);
            res_cnt = 2'd1;
          end
          cip_pkg::POS_SRC2: begin
            if (data_byte > 8'd1) begin
              fail_en  = 1'b1;
              fail_err = cip_pkg::ERR_TECHNIQUE;
            end else begin
              st_nxt.lossless = data_byte[0];
              res[0]          = mk(cip_pkg::FLD_TECHNIQUE, {8'd0, data_byte}, 1'b0);
              res_cnt         = 2'd1;
            end
          end
          cip_pkg::POS_SRC3: begin
            res[0]  = mk(cip_pkg::FLD_REFINTERVAL, {8'd0, data_byte} + 16'd1, 1'b0);
            res_cnt = 2'd1;
          end
          cip_pkg::POS_PRE0: begin
            // Preprocessor field, first byte (lossless only)
            if (data_byte[7:6] != 2'd0) begin
              fail_en  = 1'b1;
              fail_err = cip_pkg::ERR_PREPROC_HDR;
            end else begin
              st_nxt.preproc = data_byte[5];
              if (!data_byte[5]) begin
                res[0]  = mk(cip_pkg::FLD_PREPROC, 16'd0, 1'b0);
                res_cnt = 2'd1;
              end else if (!pred_ok) begin
                fail_en  = 1'b1;
                fail_err = cip_pkg::ERR_PREDICTOR;
              end else if (!map_ok) begin
                fail_en  = 1'b1;
                fail_err = cip_pkg::ERR_MAPPER;
              end else begin
                res[0]  = mk(cip_pkg::FLD_PREPROC, 16'd1, 1'b0);
                res[1]  = mk(cip_pkg::FLD_PREDICTOR, pred_val, 1'b0);
                res[2]  = mk(cip_pkg::FLD_MAPPER, map_val, 1'b0);
                res_cnt = 2'd3;
              end
            end
          end
          cip_pkg::POS_PRE1: begin
            // Preprocessor field, second byte (lossless only)
            if (data_byte[7:6] == 2'd2) begin
              fail_en  = 1'b1;
              fail_err = cip_pkg::ERR_BLOCK_RSVD;
            end else if (data_byte[7:6] == 2'd3) begin
              fail_en  = 1'b1;
              fail_err = cip_pkg::ERR_BLOCK_APP;
            end else if (!cur.preproc && !data_byte[5]) begin
              fail_en  = 1'b1;
              fail_err = cip_pkg::ERR_SENSE;
            end else begin
              st_nxt.resolution = new_res;
              res[0]  = mk(cip_pkg::FLD_BLOCK, data_byte[6] ? 16'd16 : 16'd8, 1'b0);
              res[1]  = mk(cip_pkg::FLD_SENSE, {15'd0, data_byte[5]}, 1'b0);
              res[2]  = mk(cip_pkg::FLD_RESOLUTION, {10'd0, new_res}, 1'b0);
              res_cnt = 2'd3;
            end
          end
          default: begin
            st_nxt.idle = 1'b1;
          end
        endcase
      end

      // A failed check replaces everything with one final error result
      if (fail_en) begin
        res                   = '0;
        res[0].field_code     = cip_pkg::FLD_TYPE;
        res[0].field_value    = 16'd0;
        res[0].error_code     = fail_err;
        res[0].last_result    = 1'b1;
        res_cnt               = 2'd1;
        st_nxt.idle           = 1'b1;
      end
    end
  end

  // Advance the parse state on each consumed byte; reset waits for a first byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{pos: 4'd0, idle: 1'b1, held: 8'd0, lossless: 1'b0, preproc: 1'b0,
                resolution: 6'd0, data_len: 16'd0};
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cip_result_buf.sv
// Three-slot result register: loads all results of one byte, drains one per transfer.
// Depends on cip_pkg for the result types.
`default_nettype none

module cip_result_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire logic [1:0]        load_cnt,
  input  wire cip_pkg::res_vec_t load_res,
  output logic                   can_load,
  output logic                   out_vld,
  input  wire logic              out_rdy,
  output cip_pkg::result_t       out_res
);

  cip_pkg::res_vec_t slot_r;
  logic [1:0]        cnt_r;
  logic              pop;

  assign out_vld  = (cnt_r != 2'd0);
  assign out_res  = slot_r[0];
  assign pop      = out_vld && out_rdy;
  // Room for a new set once the last held result leaves
  assign can_load = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);

  // Hold the count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= load_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Load or shift the slots
  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= load_res;
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

endmodule

`default_nettype wire

// File: rtl/cip_header_parser_top.sv
// Top level of the compression identification packet header parser.
// Depends on cip_pkg, cip_decode and cip_result_buf.
`default_nettype none

// Parses a compression identification packet one byte per input transfer and
// emits each decoded header field as a field code and value; a failed check
// emits a single error result with last_result set and the parser then ignores
// bytes until one arrives with in_first_byte set. A byte is registered on
// input, decoded in the next cycle and its results written into a three-slot
// result register once it has room. Bytes that give zero or one result stream
// at one per cycle while the output is ready; the two preprocessor bytes of a
// lossless packet give up to three results each and hold the input, the rate
// being set by the result register draining one result per output transfer.
module cip_header_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_field_code,
  output logic [15:0]      out_field_value,
  output logic [3:0]       out_error_code,
  output logic             out_last_result
);

  logic              in_vld_r;
  logic              in_vld_nxt;
  logic [7:0]        in_byte_r;
  logic              in_first_r;
  logic              step;
  logic              can_load;
  logic [1:0]        res_cnt;
  cip_pkg::res_vec_t res;
  cip_pkg::result_t  out_res;

  // Consume the held byte when its results fit
  assign step     = in_vld_r && ((res_cnt == 2'd0) || can_load);
  assign in_ready = !in_vld_r || step;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r  <= in_data_byte;
      in_first_r <= in_first_byte;
    end
  end

  cip_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data_byte  (in_byte_r),
    .first_byte (in_first_r),
    .res_cnt    (res_cnt),
    .res        (res)
  );

  cip_result_buf u_result_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step && (res_cnt != 2'd0)),
    .load_cnt (res_cnt),
    .load_res (res),
    .can_load (can_load),
    .out_vld  (out_valid),
    .out_rdy  (out_ready),
    .out_res  (out_res)
  );

  assign out_field_code  = out_res.field_code;
  assign out_field_value = out_res.field_value;
  assign out_error_code  = out_res.error_code;
  assign out_last_result = out_res.last_result;

`ifndef SYNTHESIS
  // Results are only loaded when the buffer has room
  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (res_cnt != 2'd0)) |-> can_load)
    else $error("result set loaded into occupied buffer");

  // An error result always ends the packet
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_error_code != cip_pkg::ERR_NONE)) |-> out_last_result)
    else $error("error result without last flag");

  // A final success result carries the cds field
  a_cds_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result && (out_error_code == cip_pkg::ERR_NONE))
      |-> (out_field_code == cip_pkg::FLD_CDS))
    else $error("final success result is not cds");

  // An accepted byte is held in the input register
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> in_vld_r)
    else $error("accepted byte lost");
`endif

endmodule

`default_nettype wire
